// ----- src/rounded_rect_pixel_shader_core_defines.svh -----
// assertion macros used by the rounded rectangle shader rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef ROUNDED_RECT_PIXEL_SHADER_CORE_DEFINES_SVH
`define ROUNDED_RECT_PIXEL_SHADER_CORE_DEFINES_SVH

// checked at every clock edge outside reset
`define RRPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define RRPS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rrps_pkg.sv -----
// shared constants, register codes and types of the rounded rectangle shader
// no dependencies
package rrps_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int MAX_SIDE    = 4096;
    localparam int SIDE_W      = 13;
    localparam int COORD_W     = 12;
    localparam int RAD_W       = 12;
    localparam int CH_W        = 8;
    localparam int D_W         = 24;
    localparam int ROOT_W      = (D_W + 2 * FRAC_BITS) / 2;
    localparam int REM_W       = ROOT_W + 3;
    localparam int RADX_W      = 2 * ROOT_W;
    localparam int SQRT_STAGES = ROOT_W / 2;
    localparam int T_W         = FRAC_BITS + 1;
    localparam int PROD_W      = T_W + CH_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [T_W-1:0] ONE_T = T_W'(2 ** FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH     = 3'd0,
        REG_HEIGHT    = 3'd1,
        REG_RAD_TL    = 3'd2,
        REG_RAD_TR    = 3'd3,
        REG_RAD_BL    = 3'd4,
        REG_RAD_BR    = 3'd5,
        REG_BORDER    = 3'd6,
        REG_COLOURS   = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_ZERO    = 3'd0,
        MODE_INNER   = 3'd1,
        MODE_BORDER  = 3'd2,
        MODE_BLEND   = 3'd3,
        MODE_FADE_IN = 3'd4,
        MODE_FADE_BD = 3'd5
    } shade_mode_t;

    typedef struct packed {
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
        logic [RAD_W-1:0]  r_tl;
        logic [RAD_W-1:0]  r_tr;
        logic [RAD_W-1:0]  r_bl;
        logic [RAD_W-1:0]  r_br;
        logic [SIDE_W-1:0] bt;
    } geom_cfg_t;

    typedef struct packed {
        shade_mode_t       mode;
        logic [SIDE_W-1:0] ring_rad;
    } shade_meta_t;

endpackage

// ----- src/rounded_rect_pixel_shader_core.sv -----
// top level of the antialiased rounded rectangle pixel shader
// depends on rrps_pkg, rrps_geom, rrps_isqrt and rrps_shade
//
// usage
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data writes one of
//   width, height, four corner radii, border thickness and the color pair;
//   cfg_ready is always high. write it only while no request is in flight.
//   in channel: in_valid/in_ready carries pixel_x, pixel_y of one pixel.
//   out channel: out_valid/out_ready returns alpha, red, green, blue.
//   throughput: one pixel per clock while out_ready lets the pipeline move and
//   no config write holds in_ready low. 18 register stages: five geometry
//   stages, the ten stage square root unit (two root bits per stage) and three
//   color stages.
//   in_ready drops for the cycle after a config write while the clamped radii
//   settle into their register.
//   reset: all config registers read zero and the pipeline is empty.
//   stall: while a result waits on out_ready the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated.
module rounded_rect_pixel_shader_core
    import rrps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_W-1:0]     pixel_x,
    input  logic [COORD_W-1:0]     pixel_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CH_W-1:0]        alpha,
    output logic [CH_W-1:0]        red,
    output logic [CH_W-1:0]        green,
    output logic [CH_W-1:0]        blue
);

    logic [SIDE_W-1:0]     width_reg, height_reg, border_reg;
    logic [SIDE_W-1:0]     rad_tl_reg, rad_tr_reg, rad_bl_reg, rad_br_reg;
    logic [CFG_DATA_W-1:0] colour_reg;
    geom_cfg_t             geom_cfg_reg, geom_cfg_next;
    logic [SIDE_W-1:0]     w_sat, h_sat, short_side;
    logic                  en;
    logic                  cfg_hold_reg;
    logic                  in_take;

    assign cfg_ready = 1'b1;

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            rad_tl_reg <= '0;
            rad_tr_reg <= '0;
            rad_bl_reg <= '0;
            rad_br_reg <= '0;
            border_reg <= '0;
            colour_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:   width_reg  <= cfg_data[SIDE_W-1:0];
                REG_HEIGHT:  height_reg <= cfg_data[SIDE_W-1:0];
                REG_RAD_TL:  rad_tl_reg <= cfg_data[SIDE_W-1:0];
                REG_RAD_TR:  rad_tr_reg <= cfg_data[SIDE_W-1:0];
                REG_RAD_BL:  rad_bl_reg <= cfg_data[SIDE_W-1:0];
                REG_RAD_BR:  rad_br_reg <= cfg_data[SIDE_W-1:0];
                REG_BORDER:  border_reg <= cfg_data[SIDE_W-1:0];
                REG_COLOURS: colour_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // marks the cycle after a config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_hold_reg <= 1'b0;
        else
            cfg_hold_reg <= cfg_valid && cfg_ready;
    end

    // radius limited to half the shorter side
    function automatic logic [RAD_W-1:0] clamp_rad(logic [SIDE_W-1:0] ms,
                                                   logic [SIDE_W-1:0] r);
        logic [RAD_W-1:0] res;
        if ({r, 1'b0} > {1'b0, ms})
            res = RAD_W'(ms >> 1);
        else
            res = r[RAD_W-1:0];
        return res;
    endfunction

    // saturated sides and clamped radii
    always_comb
    begin
        w_sat    = (width_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : width_reg;
        h_sat    = (height_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : height_reg;
        short_side = (w_sat < h_sat) ? w_sat : h_sat;
        geom_cfg_next.w    = w_sat;
        geom_cfg_next.h    = h_sat;
        geom_cfg_next.r_tl = clamp_rad(short_side, rad_tl_reg);
        geom_cfg_next.r_tr = clamp_rad(short_side, rad_tr_reg);
        geom_cfg_next.r_bl = clamp_rad(short_side, rad_bl_reg);
        geom_cfg_next.r_br = clamp_rad(short_side, rad_br_reg);
        geom_cfg_next.bt   = border_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            geom_cfg_reg <= '0;
        else
            geom_cfg_reg <= geom_cfg_next;
    end

    // global advance: move when the output stage is free or being taken
    assign en       = !out_valid || out_ready;
    assign in_ready = en && !cfg_hold_reg;
    assign in_take  = in_valid && !cfg_hold_reg;

    logic              g_valid, s_valid;
    logic [D_W-1:0]    g_d;
    shade_meta_t       g_meta, s_meta;
    logic [ROOT_W-1:0] s_root;

    rrps_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_take),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .cfg       (geom_cfg_reg),
        .out_valid (g_valid),
        .out_d     (g_d),
        .out_meta  (g_meta)
    );

    rrps_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid),
        .in_d      (g_d),
        .in_meta   (g_meta),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_meta  (s_meta)
    );

    rrps_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .in_root   (s_root),
        .in_meta   (s_meta),
        .colours   (colour_reg),
        .out_valid (out_valid),
        .alpha     (alpha),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

// ----- src/rrps_geom.sv -----
// geometry front end: corner pick, squared distance and shading mode
// depends on rrps_pkg
module rrps_geom
    import rrps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [COORD_W-1:0]  pixel_x,
    input  logic [COORD_W-1:0]  pixel_y,
    input  geom_cfg_t           cfg,
    output logic                out_valid,
    output logic [D_W-1:0]      out_d,
    output shade_meta_t         out_meta
);

    // stage a: rectangle test, corner select
    logic [SIDE_W-1:0]  x13, y13, rx13, ry13;
    logic [COORD_W-1:0] rx, ry;
    logic [SIDE_W:0]    x14, y14, bt14, w14, h14;
    logic               in_rect, flat_inner;
    logic               corner_next;
    logic [RAD_W-1:0]   rad_next;
    logic [COORD_W-1:0] i_next, j_next;
    shade_mode_t        flat_next;

    logic               a_valid_reg, a_corner_reg;
    shade_mode_t        a_flat_reg;
    logic [RAD_W-1:0]   a_rad_reg;
    logic [COORD_W-1:0] a_i_reg, a_j_reg;

    always_comb
    begin
        x13  = {1'b0, pixel_x};
        y13  = {1'b0, pixel_y};
        rx13 = cfg.w - x13 - SIDE_W'(1);
        ry13 = cfg.h - y13 - SIDE_W'(1);
        rx   = rx13[COORD_W-1:0];
        ry   = ry13[COORD_W-1:0];
        x14  = {2'b00, pixel_x};
        y14  = {2'b00, pixel_y};
        bt14 = {1'b0, cfg.bt};
        w14  = {1'b0, cfg.w};
        h14  = {1'b0, cfg.h};
        in_rect = (x13 < cfg.w) && (y13 < cfg.h);
        flat_inner = (cfg.bt == '0) ||
                     ((x14 >= bt14) && (x14 + bt14 < w14) &&
                      (y14 >= bt14) && (y14 + bt14 < h14));
        corner_next = in_rect;
        rad_next    = '0;
        i_next      = pixel_x;
        j_next      = pixel_y;
        if (pixel_x < cfg.r_tl && pixel_y < cfg.r_tl)
        begin
            rad_next = cfg.r_tl;
        end
        else if (rx < cfg.r_tr && pixel_y < cfg.r_tr)
        begin
            rad_next = cfg.r_tr;
            i_next   = rx;
        end
        else if (rx < cfg.r_br && ry < cfg.r_br)
        begin
            rad_next = cfg.r_br;
            i_next   = rx;
            j_next   = ry;
        end
        else if (pixel_x < cfg.r_bl && ry < cfg.r_bl)
        begin
            rad_next = cfg.r_bl;
            j_next   = ry;
        end
        else
        begin
            corner_next = 1'b0;
        end
        if (!in_rect)
            flat_next = MODE_ZERO;
        else if (flat_inner)
            flat_next = MODE_INNER;
        else
            flat_next = MODE_BORDER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_corner_reg <= corner_next;
            a_flat_reg   <= flat_next;
            a_rad_reg    <= rad_next;
            a_i_reg      <= i_next;
            a_j_reg      <= j_next;
        end
    end

    // stage b: offsets from the corner center, inner ring radius
    logic               b_valid_reg, b_corner_reg, b_pos_reg;
    shade_mode_t        b_flat_reg;
    logic [RAD_W-1:0]   b_rad_reg, b_di_reg, b_dj_reg, b_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_corner_reg <= a_corner_reg;
            b_flat_reg   <= a_flat_reg;
            b_rad_reg    <= a_rad_reg;
            b_di_reg     <= a_rad_reg - a_i_reg;
            b_dj_reg     <= a_rad_reg - a_j_reg;
            b_pos_reg    <= (cfg.bt != '0) && (cfg.bt < {1'b0, a_rad_reg});
            b_b_reg      <= a_rad_reg - cfg.bt[RAD_W-1:0];
        end
    end

    // stage c: squares
    logic               c_valid_reg, c_corner_reg, c_pos_reg;
    shade_mode_t        c_flat_reg;
    logic [RAD_W-1:0]   c_rad_reg, c_b_reg;
    logic [D_W-1:0]     c_sqi_reg, c_sqj_reg, c_r2_reg, c_r12_reg, c_b2_reg, c_b12_reg;
    logic [SIDE_W-1:0]  b_rad1, b_b1;

    assign b_rad1 = {1'b0, b_rad_reg} + SIDE_W'(1);
    assign b_b1   = {1'b0, b_b_reg} + SIDE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_corner_reg <= b_corner_reg;
            c_flat_reg   <= b_flat_reg;
            c_pos_reg    <= b_pos_reg;
            c_rad_reg    <= b_rad_reg;
            c_b_reg      <= b_b_reg;
            c_sqi_reg    <= D_W'(b_di_reg) * D_W'(b_di_reg);
            c_sqj_reg    <= D_W'(b_dj_reg) * D_W'(b_dj_reg);
            c_r2_reg     <= D_W'(b_rad_reg) * D_W'(b_rad_reg);
            c_r12_reg    <= D_W'(b_rad1) * D_W'(b_rad1);
            c_b2_reg     <= D_W'(b_b_reg) * D_W'(b_b_reg);
            c_b12_reg    <= D_W'(b_b1) * D_W'(b_b1);
        end
    end

    // stage d: squared distance
    logic               d_valid_reg, d_corner_reg, d_pos_reg;
    shade_mode_t        d_flat_reg;
    logic [RAD_W-1:0]   d_rad_reg, d_b_reg;
    logic [D_W-1:0]     d_d_reg, d_r2_reg, d_r12_reg, d_b2_reg, d_b12_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_corner_reg <= c_corner_reg;
            d_flat_reg   <= c_flat_reg;
            d_pos_reg    <= c_pos_reg;
            d_rad_reg    <= c_rad_reg;
            d_b_reg      <= c_b_reg;
            d_d_reg      <= c_sqi_reg + c_sqj_reg;
            d_r2_reg     <= c_r2_reg;
            d_r12_reg    <= c_r12_reg;
            d_b2_reg     <= c_b2_reg;
            d_b12_reg    <= c_b12_reg;
        end
    end

    // stage e: distance compares pick the shading mode
    shade_meta_t        meta_next;
    logic               e_valid_reg;
    logic [D_W-1:0]     e_d_reg;
    shade_meta_t        e_meta_reg;

    always_comb
    begin
        meta_next.mode     = d_flat_reg;
        meta_next.ring_rad = {1'b0, d_rad_reg} + SIDE_W'(1);
        if (d_corner_reg)
        begin
            if (d_pos_reg && d_d_reg < d_b2_reg)
                meta_next.mode = MODE_INNER;
            else if (d_pos_reg && d_d_reg < d_b12_reg)
            begin
                meta_next.mode     = MODE_BLEND;
                meta_next.ring_rad = {1'b0, d_b_reg} + SIDE_W'(1);
            end
            else if (d_d_reg < d_r2_reg)
                meta_next.mode = (cfg.bt == '0) ? MODE_INNER : MODE_BORDER;
            else if (d_d_reg < d_r12_reg)
                meta_next.mode = (cfg.bt == '0) ? MODE_FADE_IN : MODE_FADE_BD;
            else
                meta_next.mode = MODE_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (en)
            e_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_d_reg    <= d_d_reg;
            e_meta_reg <= meta_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_d     = e_d_reg;
    assign out_meta  = e_meta_reg;

endmodule

// ----- src/rrps_isqrt.sv -----
// pipelined integer square root of the squared distance scaled by 2^(2*FRAC_BITS)
// two root bits per stage; depends on rrps_pkg
module rrps_isqrt
    import rrps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [D_W-1:0]      in_d,
    input  shade_meta_t         in_meta,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   out_root,
    output shade_meta_t         out_meta
);

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_state_t;

    // one restoring digit step
    function automatic sq_state_t sq_step(sq_state_t st, logic [1:0] pair);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        sq_state_t        nx;
        rem_sh = {st.rem[REM_W-3:0], pair};
        trial  = REM_W'({st.root, 2'b01});
        if (rem_sh >= trial)
        begin
            nx.rem  = rem_sh - trial;
            nx.root = {st.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nx.rem  = rem_sh;
            nx.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return nx;
    endfunction

    logic              v_reg  [SQRT_STAGES];
    sq_state_t         st_reg [SQRT_STAGES];
    logic [RADX_W-1:0] x_reg  [SQRT_STAGES];
    shade_meta_t       m_reg  [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++)
    begin : g_stage
        logic              v_in;
        sq_state_t         st_in, st_mid, st_next;
        logic [RADX_W-1:0] x_in;
        shade_meta_t       m_in;

        if (g == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign st_in = '0;
            assign x_in  = {in_d, {(2 * FRAC_BITS){1'b0}}};
            assign m_in  = in_meta;
        end
        else
        begin : g_later
            assign v_in  = v_reg[g-1];
            assign st_in = st_reg[g-1];
            assign x_in  = x_reg[g-1];
            assign m_in  = m_reg[g-1];
        end

        // two digits from the top of the remaining radicand
        always_comb
        begin
            st_mid  = sq_step(st_in, x_in[RADX_W-1 -: 2]);
            st_next = sq_step(st_mid, x_in[RADX_W-3 -: 2]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (en)
                v_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g] <= st_next;
                x_reg[g]  <= x_in << 4;
                m_reg[g]  <= m_in;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_root  = st_reg[SQRT_STAGES-1].root;
    assign out_meta  = m_reg[SQRT_STAGES-1];

endmodule

// ----- src/rrps_shade.sv -----
// back end: edge weight, channel products and output color register
// depends on rrps_pkg and the assertion macro header
`include "rounded_rect_pixel_shader_core_defines.svh"
module rrps_shade
    import rrps_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [ROOT_W-1:0]       in_root,
    input  shade_meta_t             in_meta,
    input  logic [CFG_DATA_W-1:0]   colours,
    output logic                    out_valid,
    output logic [CH_W-1:0]         alpha,
    output logic [CH_W-1:0]         red,
    output logic [CH_W-1:0]         green,
    output logic [CH_W-1:0]         blue
);

    localparam int TF_W = SIDE_W + FRAC_BITS;

    logic [3:0][CH_W-1:0] ic, bc;

    assign ic = colours[31:0];
    assign bc = colours[63:32];

    // stage f: weight of the inner side of the edge
    logic [TF_W-1:0] t_full;
    logic            f_valid_reg;
    logic [T_W-1:0]  f_t_reg;
    shade_mode_t     f_mode_reg;

    assign t_full = {in_meta.ring_rad, {FRAC_BITS{1'b0}}} - TF_W'(in_root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (en)
            f_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_t_reg    <= t_full[T_W-1:0];
            f_mode_reg <= in_meta.mode;
        end
    end

    // stage g: per channel products
    logic [3:0][CH_W-1:0]   src;
    logic [T_W-1:0]         t_inv;
    logic                   g_valid_reg;
    shade_mode_t            g_mode_reg;
    logic [3:0][PROD_W-1:0] g_pa_reg, g_pb_reg;

    assign src   = (f_mode_reg == MODE_FADE_BD) ? bc : ic;
    assign t_inv = ONE_T - f_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (en)
            g_valid_reg <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_mode_reg <= f_mode_reg;
            for (int k = 0; k < 4; k++)
            begin
                g_pa_reg[k] <= PROD_W'(f_t_reg) * PROD_W'(src[k]);
                g_pb_reg[k] <= PROD_W'(t_inv) * PROD_W'(bc[k]);
            end
        end
    end

    // stage h: final color select
    logic [3:0][CH_W-1:0] col_next;
    logic [3:0][CH_W-1:0] out_col_reg;
    logic                 out_valid_reg;
    logic [PROD_W:0]      sum;

    always_comb
    begin
        col_next = '0;
        sum      = '0;
        case (g_mode_reg)
            MODE_ZERO:    col_next = '0;
            MODE_INNER:   col_next = ic;
            MODE_BORDER:  col_next = bc;
            MODE_BLEND:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    sum = {1'b0, g_pa_reg[k]} + {1'b0, g_pb_reg[k]};
                    col_next[k] = sum[FRAC_BITS+CH_W-1:FRAC_BITS];
                end
            end
            MODE_FADE_IN:
            begin
                col_next    = ic;
                col_next[3] = g_pa_reg[3][FRAC_BITS+CH_W-1:FRAC_BITS];
            end
            MODE_FADE_BD:
            begin
                col_next    = bc;
                col_next[3] = g_pa_reg[3][FRAC_BITS+CH_W-1:FRAC_BITS];
            end
            default:      col_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= g_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_col_reg <= col_next;
    end

    assign out_valid = out_valid_reg;
    assign alpha     = out_col_reg[3];
    assign red       = out_col_reg[2];
    assign green     = out_col_reg[1];
    assign blue      = out_col_reg[0];

    // edge weight stays within one pixel on every blended or faded request
    `RRPS_ASSERT(a_weight_range, f_valid_reg && (f_mode_reg == MODE_BLEND || f_mode_reg == MODE_FADE_IN || f_mode_reg == MODE_FADE_BD) |-> (f_t_reg != '0 && f_t_reg <= ONE_T), "edge weight out of range")
    // no result appears without a request behind it
    `RRPS_ASSERT(a_no_phantom, en && !g_valid_reg |=> !out_valid_reg, "result without request")
    // a stall freezes the output stage
    `RRPS_ASSERT(a_stall_hold, !en |=> $stable(out_valid_reg) && $stable(out_col_reg), "output moved while stalled")
    // reset empties the output stage
    `RRPS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_reg, "valid result during reset")

endmodule

// ----- sim/tb.sv -----
// self-checking testbench of the rounded rectangle pixel shader core
// depends on rrps_pkg and rounded_rect_pixel_shader_core
// pixel colors are predicted in place and compared channel by channel
`timescale 1ns / 1ps

module tb;
    import rrps_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [COORD_W-1:0]    pixel_x = '0;
    logic [COORD_W-1:0]    pixel_y = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CH_W-1:0]       alpha, red, green, blue;

    // shadow copy of the registers and the queue of expected pixel colors
    longint unsigned shadow_reg [8];
    logic [31:0]     expected_argb [$];
    bit              failed = 1'b0;
    bit              no_gaps = 1'b0;
    int              ready_hold = 0;

    typedef struct {
        bit          is_write;
        cfg_reg_t    reg_idx;
        logic [63:0] value;
        int          px;
        int          py;
        bit          typed;
        logic [31:0] argb;
    } stim_row_t;

    rounded_rect_pixel_shader_core dut (.*);

    always #6 clk = ~clk;

    // integer square root, bit by bit
    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint chan(logic [31:0] c, int k);
        return longint'(c[31-8*k -: 8]);
    endfunction

    // shading of one corner pixel from its squared distance to the center
    function automatic logic [31:0] corner_argb(longint rad, longint i, longint j,
                                                longint bt, logic [31:0] inner,
                                                logic [31:0] border);
        longint unsigned one, s, t, v;
        longint di, dj, d, b;
        logic [31:0] outer, o;
        one = 64'd1 << FRAC_BITS;
        di = rad - i;
        dj = rad - j;
        d = di * di + dj * dj;
        s = int_root(longint'(d) << (2 * FRAC_BITS));
        outer = (bt == 0) ? inner : border;
        b = rad - bt;
        o = '0;
        if (bt != 0 && b > 0)
        begin
            if (d < b * b)
                return inner;
            if (d < (b + 1) * (b + 1))
            begin
                t = (longint'(b + 1) << FRAC_BITS) - s;
                for (int k = 0; k < 4; k++)
                begin
                    v = (t * chan(inner, k) + (one - t) * chan(border, k)) >> FRAC_BITS;
                    o[31-8*k -: 8] = v[7:0];
                end
                return o;
            end
        end
        if (d < rad * rad)
            o = outer;
        else if (d < (rad + 1) * (rad + 1))
        begin
            t = (longint'(rad + 1) << FRAC_BITS) - s;
            v = (t * chan(outer, 0)) >> FRAC_BITS;
            o = {v[7:0], outer[23:0]};
        end
        return o;
    endfunction

    function automatic longint clamp_radius(longint short_side, longint r);
        return (r * 2 > short_side) ? short_side / 2 : r;
    endfunction

    // color of one pixel under the current register settings
    function automatic logic [31:0] shade_pixel(longint x, longint y);
        longint w, h, bt, ms, rtl, rtr, rbl, rbr, rx, ry;
        logic [31:0] ic, bc;
        bit inner;
        w = (shadow_reg[REG_WIDTH] > MAX_SIDE) ? MAX_SIDE : shadow_reg[REG_WIDTH];
        h = (shadow_reg[REG_HEIGHT] > MAX_SIDE) ? MAX_SIDE : shadow_reg[REG_HEIGHT];
        bt = shadow_reg[REG_BORDER];
        ms = (w < h) ? w : h;
        rtl = clamp_radius(ms, shadow_reg[REG_RAD_TL]);
        rtr = clamp_radius(ms, shadow_reg[REG_RAD_TR]);
        rbl = clamp_radius(ms, shadow_reg[REG_RAD_BL]);
        rbr = clamp_radius(ms, shadow_reg[REG_RAD_BR]);
        ic = shadow_reg[REG_COLOURS][31:0];
        bc = shadow_reg[REG_COLOURS][63:32];
        if (!(x < w && y < h))
            return '0;
        rx = w - 1 - x;
        ry = h - 1 - y;
        if (x < rtl && y < rtl)
            return corner_argb(rtl, x, y, bt, ic, bc);
        if (rx < rtr && y < rtr)
            return corner_argb(rtr, rx, y, bt, ic, bc);
        if (rx < rbr && ry < rbr)
            return corner_argb(rbr, rx, ry, bt, ic, bc);
        if (x < rbl && ry < rbl)
            return corner_argb(rbl, x, ry, bt, ic, bc);
        inner = (bt == 0) || (x >= bt && x < w - bt && y >= bt && y < h - bt);
        return inner ? ic : bc;
    endfunction

    // register write, valid is left high for a following write
    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        shadow_reg[idx] = (idx == REG_COLOURS) ? value : (value & 64'h1FFF);
    endtask

    // drain the pipeline before touching the registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (expected_argb.size() != 0) @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    // one pixel request, optionally preceded by a gap
    task automatic send_pixel(int px, int py, bit typed, logic [31:0] argb);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x <= px[COORD_W-1:0];
        pixel_y <= py[COORD_W-1:0];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_argb.push_back(typed ? argb : shade_pixel(px, py));
    endtask

    function automatic int pick_side();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 4096;
            2:       return $urandom_range(4097, 8191);
            3:       return $urandom_range(1, 4095);
            default: return $urandom_range(1, 90);
        endcase
    endfunction

    function automatic int pick_radius();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(0, 8191);
            default: return $urandom_range(1, 50);
        endcase
    endfunction

    // result side: random stalls and the channel compare
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (out_valid && out_ready)
        begin
            if (expected_argb.size() == 0)
            begin
                $display("%0t: unexpected pixel %h%h%h%h", $time, alpha, red, green, blue);
                failed = 1'b1;
            end
            else
            begin
                want = expected_argb.pop_front();
                if (alpha !== want[31:24])
                begin
                    $display("%0t: alpha expected %h actual %h", $time, want[31:24], alpha);
                    failed = 1'b1;
                end
                if (red !== want[23:16])
                begin
                    $display("%0t: red expected %h actual %h", $time, want[23:16], red);
                    failed = 1'b1;
                end
                if (green !== want[15:8])
                begin
                    $display("%0t: green expected %h actual %h", $time, want[15:8], green);
                    failed = 1'b1;
                end
                if (blue !== want[7:0])
                begin
                    $display("%0t: blue expected %h actual %h", $time, want[7:0], blue);
                    failed = 1'b1;
                end
            end
        end
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready <= 1'b0;
        end
        else if (!no_gaps && $urandom_range(0, 4) == 0)
        begin
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // run limit
    initial
    begin
        #50ms;
        $display("rounded_rect_pixel_shader_core: mismatch");
        $finish;
    end

    initial
    begin
        stim_row_t rows [$];
        int w, h;
        for (int k = 0; k < 8; k++) shadow_reg[k] = 0;

        // directed stimulus: after reset, a bordered shape, a thick border,
        // oversized sides with huge radii
        rows = '{
            '{0, REG_WIDTH, 0, 0, 0, 1, 32'h0},
            '{0, REG_WIDTH, 0, 4095, 4095, 1, 32'h0},
            '{1, REG_WIDTH, 64'd64, 0, 0, 0, 0},
            '{1, REG_HEIGHT, 64'd40, 0, 0, 0, 0},
            '{1, REG_RAD_TL, 64'd10, 0, 0, 0, 0},
            '{1, REG_RAD_TR, 64'd30, 0, 0, 0, 0},
            '{1, REG_RAD_BL, 64'd0, 0, 0, 0, 0},
            '{1, REG_RAD_BR, 64'd8, 0, 0, 0, 0},
            '{1, REG_BORDER, 64'd3, 0, 0, 0, 0},
            '{1, REG_COLOURS, 64'hFF112233_80AABBCC, 0, 0, 0, 0},
            '{0, REG_WIDTH, 0, 0, 0, 0, 0},
            '{0, REG_WIDTH, 0, 5, 5, 0, 0},
            '{0, REG_WIDTH, 0, 2, 6, 0, 0},
            '{0, REG_WIDTH, 0, 63, 0, 0, 0},
            '{0, REG_WIDTH, 0, 50, 12, 0, 0},
            '{0, REG_WIDTH, 0, 63, 39, 0, 0},
            '{0, REG_WIDTH, 0, 0, 39, 1, 32'hFF112233},
            '{0, REG_WIDTH, 0, 32, 20, 1, 32'h80AABBCC},
            '{0, REG_WIDTH, 0, 1, 20, 1, 32'hFF112233},
            '{0, REG_WIDTH, 0, 64, 0, 1, 32'h0},
            '{0, REG_WIDTH, 0, 0, 40, 1, 32'h0},
            '{0, REG_WIDTH, 0, 4095, 0, 1, 32'h0},
            '{1, REG_BORDER, 64'd30, 0, 0, 0, 0},
            '{0, REG_WIDTH, 0, 2, 2, 0, 0},
            '{0, REG_WIDTH, 0, 32, 20, 1, 32'hFF112233},
            '{1, REG_WIDTH, 64'd8191, 0, 0, 0, 0},
            '{1, REG_HEIGHT, 64'd4096, 0, 0, 0, 0},
            '{1, REG_RAD_TL, 64'd4096, 0, 0, 0, 0},
            '{1, REG_RAD_BR, 64'd8191, 0, 0, 0, 0},
            '{1, REG_BORDER, 64'd0, 0, 0, 0, 0},
            '{1, REG_COLOURS, 64'hFFFFFFFF_FFFFFFFF, 0, 0, 0, 0},
            '{0, REG_WIDTH, 0, 0, 0, 0, 0},
            '{0, REG_WIDTH, 0, 2048, 2048, 0, 0},
            '{0, REG_WIDTH, 0, 4095, 4095, 0, 0},
            '{0, REG_WIDTH, 0, 100, 0, 0, 0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[n])
        begin
            if (rows[n].is_write)
            begin
                if (n == 0 || !rows[n-1].is_write)
                    wait_idle();
                write_reg(rows[n].reg_idx, rows[n].value);
            end
            else
            begin
                if (n != 0 && rows[n-1].is_write)
                    cfg_valid <= 1'b0;
                send_pixel(rows[n].px, rows[n].py, rows[n].typed, rows[n].argb);
            end
        end

        // random phases: new shape, then mostly pixels near it
        for (int phase = 0; phase < 13; phase++)
        begin
            wait_idle();
            no_gaps = (phase % 4 == 3);
            write_reg(REG_WIDTH, pick_side());
            write_reg(REG_HEIGHT, pick_side());
            write_reg(REG_RAD_TL, pick_radius());
            write_reg(REG_RAD_TR, pick_radius());
            write_reg(REG_RAD_BL, pick_radius());
            write_reg(REG_RAD_BR, pick_radius());
            write_reg(REG_BORDER, ($urandom_range(0, 2) == 0) ? 0 :
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) :
                      $urandom_range(1, 20));
            write_reg(REG_COLOURS, {$urandom, $urandom});
            cfg_valid <= 1'b0;
            w = (shadow_reg[REG_WIDTH] > MAX_SIDE) ? MAX_SIDE : shadow_reg[REG_WIDTH];
            h = (shadow_reg[REG_HEIGHT] > MAX_SIDE) ? MAX_SIDE : shadow_reg[REG_HEIGHT];
            for (int n = 0; n < 150; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), 0, 0);
                else if ($urandom_range(0, 3) == 0 && w > 0 && h > 0)
                    send_pixel(w - 1 - $urandom_range(0, (w < 60) ? w - 1 : 59),
                               h - 1 - $urandom_range(0, (h < 60) ? h - 1 : 59), 0, 0);
                else
                    send_pixel($urandom_range(0, (w < 4092) ? w + 3 : 4095),
                               $urandom_range(0, (h < 4092) ? h + 3 : 4095), 0, 0);
            end
        end

        wait_idle();
        if (!failed)
            $display("rounded_rect_pixel_shader_core: match");
        else
            $display("rounded_rect_pixel_shader_core: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/rrps_pkg.sv
src/rrps_geom.sv
src/rrps_isqrt.sv
src/rrps_shade.sv
src/rounded_rect_pixel_shader_core.sv
sim/tb.sv
